// File: hdl/wgbp_pkg.sv
package wgbp_pkg;

    // Width of one data word and of the address pointer.
    localparam int WORD_W = 32;

    // Byte step between consecutive memory word writes of a burst.
    localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

    // Register indexes on the configuration port.
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // Result kinds.
    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_READBACK = 1'b1;

    // Input operation codes; OP_NONE is accepted and dropped.
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_SETPTR = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // One command as it travels from the front end to the back end.
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
    } qcmd_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_EMIT  = 2'd2
    } back_state_t;

    // Status of the command queue as seen by its two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// File: hdl/wgbp_front.sv
module wgbp_front #(
    parameter int BURST_WORDS = 8,
    parameter int IDX_W       = $clog2(BURST_WORDS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [wgbp_pkg::WORD_W-1:0] data_word,
    input  wgbp_pkg::qstat_t           q_stat,
    output logic                       q_push,
    output wgbp_pkg::qcmd_t            q_cmd,
    output logic [IDX_W-1:0]           q_idx
);
    import wgbp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BURST_WORDS - 1);

    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] fill_next;
    logic             in_xfer;
    op_t              op_code;

    // The front end takes a transfer whenever the queue has room.
    assign in_stall = q_stat.full;
    assign in_xfer  = in_valid && !q_stat.full;
    assign op_code  = op_t'(op);

    // Unused codes are taken and dropped; everything else is queued.
    assign q_push     = in_xfer && (op_code != OP_NONE);
    assign q_cmd.op   = op_code;
    assign q_cmd.word = data_word;
    assign q_idx      = fill_reg;

    // Gather slot counter: wraps after the last slot of a burst.
    always_comb
    begin
        fill_next = fill_reg;
        if (in_xfer && (op_code == OP_PUSH))
        begin
            if (fill_reg == LAST_IDX)
                fill_next = '0;
            else
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

// File: hdl/wgbp_fifo.sv
module wgbp_fifo #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output wgbp_pkg::qstat_t stat
);
    import wgbp_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign dout       = entry_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: hdl/wgbp_back.sv
module wgbp_back #(
    parameter int BURST_WORDS = 8,
    parameter int IDX_W       = $clog2(BURST_WORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wgbp_pkg::WORD_W-1:0] cfg_data,
    input  wgbp_pkg::qstat_t            q_stat,
    input  wgbp_pkg::qcmd_t             q_cmd,
    input  logic [IDX_W-1:0]            q_idx,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [wgbp_pkg::WORD_W-1:0] address,
    output logic [wgbp_pkg::WORD_W-1:0] data,
    output logic                        last
);
    import wgbp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BURST_WORDS - 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [WORD_W-1:0] base_reg;
    logic [WORD_W-1:0] thresh_reg;
    logic [WORD_W-1:0] ptr_reg;
    logic [WORD_W-1:0] ptr_next;
    logic [WORD_W-1:0] ptr_inc;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [WORD_W-1:0] gather_mem [BURST_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              kind_reg;
    logic [WORD_W-1:0] address_reg;
    logic [WORD_W-1:0] data_reg;
    logic              last_reg;
    logic              slot_free;
    logic              burst_last;
    logic              burst_start;
    logic              mem_we;
    logic              ptr_set;
    logic              load_write;
    logic              load_read;

    // The output register can take a new result when empty or being drained.
    assign slot_free   = !out_valid_reg || !out_stall;
    assign burst_last  = (rd_idx_reg == LAST_IDX);
    assign burst_start = !q_stat.empty && (q_cmd.op == OP_PUSH) && (q_idx == LAST_IDX);
    assign ptr_inc     = ptr_reg + WORD_STEP;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (burst_start)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = burst_last ? ST_IDLE : ST_FETCH;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        ptr_set    = 1'b0;
        load_write = 1'b0;
        load_read  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (q_cmd.op)
                        OP_PUSH:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_SETPTR:
                        begin
                            q_pop   = 1'b1;
                            ptr_set = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (slot_free)
                            begin
                                q_pop     = 1'b1;
                                load_read = 1'b1;
                            end
                        end
                        default:
                            q_pop = 1'b1;
                    endcase
                end
            end
            ST_FETCH:
            begin
            end
            ST_EMIT:
                load_write = slot_free;
            default:
            begin
            end
        endcase
    end

    // Pointer and burst index update; after a burst, reload from base once the pointer reaches the threshold.
    always_comb
    begin
        ptr_next    = ptr_reg;
        rd_idx_next = rd_idx_reg;
        if (ptr_set)
            ptr_next = q_cmd.word;
        else if (load_write)
        begin
            if (burst_last && (ptr_inc >= thresh_reg))
                ptr_next = base_reg;
            else
                ptr_next = ptr_inc;
        end
        if (load_write)
            rd_idx_next = burst_last ? '0 : rd_idx_reg + 1'b1;
    end

    // Output valid: set on a load, cleared once the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_write || load_read)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            thresh_reg    <= '0;
            ptr_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE:   base_reg   <= cfg_data;
                    REG_THRESH: thresh_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Gather memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            gather_mem[q_idx] <= q_cmd.word;
        rd_data_reg <= gather_mem[rd_idx_reg];
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            kind_reg    <= KIND_WRITE;
            address_reg <= ptr_reg;
            data_reg    <= rd_data_reg;
            last_reg    <= burst_last;
        end
        else if (load_read)
        begin
            kind_reg    <= KIND_READBACK;
            address_reg <= '0;
            data_reg    <= ptr_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign address   = address_reg;
    assign data      = data_reg;
    assign last      = last_reg;

endmodule

// File: hdl/write_gather_burst_pipe_top.sv
// Write-gather burst pipe.
// Input channel (in_valid / in_stall, fields op and data_word) takes one
// transfer per cycle while the two-entry command queue has room. Op push
// gathers a word, op pointer write replaces the write pointer, op read
// returns the pointer, and the unused code is taken and dropped.
// Output channel (out_valid / out_stall) carries kind, address, data and last.
// A pointer readback passes through the command queue and the output
// register. The transfer that fills the gather memory starts a burst;
// each word write is fetched by the registered read of the gather memory
// and then loaded into the output register, and the next word is fetched
// only after that load. While a burst drains the queue holds further
// commands, so the input side stalls once it is full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Reset clears the pointer, the base and threshold registers, the gather
// count and the queue; the gather memory itself keeps no reset.
// When the receiver stalls, the output register holds its result and the
// burst pauses until it is taken.
module write_gather_burst_pipe_top #(
    parameter int BURST_WORDS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wgbp_pkg::WORD_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  op,
    input  logic [wgbp_pkg::WORD_W-1:0] data_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [wgbp_pkg::WORD_W-1:0] address,
    output logic [wgbp_pkg::WORD_W-1:0] data,
    output logic                        last
);
    import wgbp_pkg::*;

    localparam int IDX_W = $clog2(BURST_WORDS);
    localparam int Q_W   = $bits(qcmd_t) + IDX_W;

    qcmd_t            f_cmd;
    logic [IDX_W-1:0] f_idx;
    logic             q_push;
    qcmd_t            b_cmd;
    logic [IDX_W-1:0] b_idx;
    logic             q_pop;
    qstat_t           q_stat;

    // Front end: accepts and classifies transfers, counts gather slots.
    wgbp_front #(
        .BURST_WORDS (BURST_WORDS),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_word (data_word),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (f_cmd),
        .q_idx     (f_idx)
    );

    // Command queue between the two halves.
    wgbp_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_cmd, f_idx}),
        .pop   (q_pop),
        .dout  ({b_cmd, b_idx}),
        .stat  (q_stat)
    );

    // Back end: gather memory, pointer and burst sequencer.
    wgbp_back #(
        .BURST_WORDS (BURST_WORDS),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_cmd     (b_cmd),
        .q_idx     (b_idx),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .address   (address),
        .data      (data),
        .last      (last)
    );

    // A readback is always a single, final result.
    a_readback_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_READBACK)) |-> (last && (address == '0)))
        else $error("readback result without last or with nonzero address");

    // Within a burst the next word write follows at an address 4 higher.
    a_burst_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (kind == KIND_WRITE) && !last) |=>
        (!out_valid || ((kind == KIND_WRITE) && (address == $past(address) + WORD_STEP))))
        else $error("burst word write out of address sequence");

    // The input side stalls only while the queue is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (q_stat.full && !q_stat.empty))
        else $error("input stalled while the command queue has room");

endmodule
